// File: sv/tun_pkg.sv
// ---------------------------------------------------------------------------
// tun_pkg: shared types and constants for the triangle unit normal block.
// Holds the field widths, the Q1.14 unit constant and the sideband words
// that travel beside the square-root and divider pipelines.
// ---------------------------------------------------------------------------
package tun_pkg;

  // Width of an input coordinate and of an output component.
  localparam int unsigned CoordW = 16;
  // Width of an edge component (difference of two coordinates).
  localparam int unsigned EdgeW  = 17;
  // Width of the product of a pair of edge components.
  localparam int unsigned ProdW  = 34;
  // Width of a cross product component and of its magnitude.
  localparam int unsigned CrossW = 35;
  // Width of a scaled magnitude: the largest one lies in [2^30, 2^31).
  localparam int unsigned RedW   = 31;
  // Bit position that the largest scaled magnitude is brought to.
  localparam int unsigned RedTop = 30;
  // Width of the sum of squares and of its integer square root.
  localparam int unsigned RadW   = 64;
  localparam int unsigned RootW  = 32;
  // Width of a rounded dividend and of a quotient.
  localparam int unsigned NumW   = 46;
  localparam int unsigned QuotW  = 16;
  // Unit length in Q1.14.
  localparam logic [QuotW-1:0] OneQ14 = 16'd16384;

  // Words that ride beside the square-root pipeline.
  typedef struct packed {
    logic                     deg;
    logic [2:0]               neg;
    logic [2:0][RedW-1:0]     red;
  } root_side_t;

  // Words that ride beside the divider pipeline.
  typedef struct packed {
    logic       deg;
    logic [2:0] neg;
  } div_side_t;

endpackage

// File: sv/tun_isqrt.sv
// ---------------------------------------------------------------------------
// tun_isqrt: pipelined integer square root.
// Gives floor(sqrt(rad)) of a 64-bit word, one root bit per register stage,
// and carries a sideband word along with each item.
// ---------------------------------------------------------------------------
module tun_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [tun_pkg::RadW-1:0]      in_rad,
  input  tun_pkg::root_side_t           in_side,
  output logic                          out_valid,
  output logic [tun_pkg::RootW-1:0]     out_root,
  output tun_pkg::root_side_t           out_side
);

  localparam int unsigned Steps = tun_pkg::RootW;

  logic                          valid_r [0:Steps];
  logic [tun_pkg::RadW-1:0]      rem_r   [0:Steps];
  logic [tun_pkg::RootW-1:0]     root_r  [0:Steps];
  tun_pkg::root_side_t           side_r  [0:Steps];

  // Entry register holds the radicand as the first remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= in_rad;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // Each stage decides one root bit, from the top bit down.
  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned K = Steps - 1 - j;
    logic [tun_pkg::RadW-1:0]  trial;
    logic [tun_pkg::RadW-1:0]  rem_nxt;
    logic [tun_pkg::RootW-1:0] root_nxt;

    always_comb begin
      trial    = (tun_pkg::RadW'(root_r[j]) << (K + 1)) |
                 (tun_pkg::RadW'(1) << (2 * K));
      rem_nxt  = rem_r[j];
      root_nxt = root_r[j];
      if (rem_r[j] >= trial) begin
        rem_nxt  = rem_r[j] - trial;
        root_nxt = root_r[j] | (tun_pkg::RootW'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j+1] <= 1'b0;
      end else if (adv) begin
        valid_r[j+1] <= valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1]  <= rem_nxt;
        root_r[j+1] <= root_nxt;
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = valid_r[Steps];
  assign out_root  = root_r[Steps];
  assign out_side  = side_r[Steps];

endmodule

// File: sv/tun_div.sv
// ---------------------------------------------------------------------------
// tun_div: three-lane pipelined rounding divider.
// Forms (red * 2^14 + len / 2) / len for three magnitudes against one
// length, one quotient bit per register stage in each lane.
// ---------------------------------------------------------------------------
module tun_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [tun_pkg::RootW-1:0]             in_len,
  input  logic [2:0][tun_pkg::RedW-1:0]         in_red,
  input  tun_pkg::div_side_t                    in_side,
  output logic                                  out_valid,
  output logic [2:0][tun_pkg::QuotW-1:0]        out_quot,
  output tun_pkg::div_side_t                    out_side
);

  localparam int unsigned Steps = tun_pkg::QuotW;
  localparam int unsigned RemW  = tun_pkg::NumW + 1;

  logic                                 valid_r [0:Steps];
  logic [tun_pkg::RootW-1:0]            len_r   [0:Steps];
  logic [2:0][RemW-1:0]                 rem_r   [0:Steps];
  logic [2:0][tun_pkg::QuotW-1:0]       quot_r  [0:Steps];
  tun_pkg::div_side_t                   side_r  [0:Steps];
  logic [2:0][RemW-1:0]                 num;

  // Rounded dividends: magnitude scaled by 2^14 plus half the length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (RemW'(in_red[i]) << 14) + RemW'(in_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r[0]  <= in_len;
      rem_r[0]  <= num;
      quot_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned B = Steps - 1 - j;
    logic [RemW-1:0]                  trial;
    logic [2:0][RemW-1:0]             rem_nxt;
    logic [2:0][tun_pkg::QuotW-1:0]   quot_nxt;

    always_comb begin
      trial    = RemW'(len_r[j]) << B;
      rem_nxt  = rem_r[j];
      quot_nxt = quot_r[j];
      for (int i = 0; i < 3; i++) begin
        if (rem_r[j][i] >= trial) begin
          rem_nxt[i]  = rem_r[j][i] - trial;
          quot_nxt[i] = quot_r[j][i] | (tun_pkg::QuotW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j+1] <= 1'b0;
      end else if (adv) begin
        valid_r[j+1] <= valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        len_r[j+1]  <= len_r[j];
        rem_r[j+1]  <= rem_nxt;
        quot_r[j+1] <= quot_nxt;
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = valid_r[Steps];
  assign out_quot  = quot_r[Steps];
  assign out_side  = side_r[Steps];

endmodule

// File: sv/triangle_unit_normal_top.sv
// ---------------------------------------------------------------------------
// triangle_unit_normal_top: unit face normal of a triangle.
// Takes three Q4.11 vertices per word and returns the Q1.14 unit normal of
// the cross product (c - a) x (b - a), with a flag for a zero-length normal.
// ---------------------------------------------------------------------------
// The block takes one word per cycle while the input is not stalled and returns
// one result word per input word, in order. It is 58 register stages deep. That
// depth is set by the square-root pipeline (an entry register and then one root
// bit per stage, 33 registers) and the divider (an entry register and then one
// quotient bit per stage, 17 registers), behind seven stages of edge, product,
// cross-product, maximum, leading-bit, scaling and squaring logic and ahead of
// one output register. The whole pipeline moves together: it holds while the
// output word is waiting and stalled, and the input stall follows from that alone.

module triangle_unit_normal_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  input  logic signed [15:0] in_c_x,
  input  logic signed [15:0] in_c_y,
  input  logic signed [15:0] in_c_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic               out_degenerate
);

  localparam int unsigned EW = tun_pkg::EdgeW;
  localparam int unsigned PW = tun_pkg::ProdW;
  localparam int unsigned CW = tun_pkg::CrossW;
  localparam int unsigned RW = tun_pkg::RedW;

  logic adv;

  // The pipeline advances unless a finished word is held at the output.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: edge vectors r = c - a and u = b - a.
  logic                     s1_valid_r;
  logic signed [2:0][EW-1:0] s1_r_r;
  logic signed [2:0][EW-1:0] s1_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r_r[0] <= EW'(in_c_x) - EW'(in_a_x);
      s1_r_r[1] <= EW'(in_c_y) - EW'(in_a_y);
      s1_r_r[2] <= EW'(in_c_z) - EW'(in_a_z);
      s1_u_r[0] <= EW'(in_b_x) - EW'(in_a_x);
      s1_u_r[1] <= EW'(in_b_y) - EW'(in_a_y);
      s1_u_r[2] <= EW'(in_b_z) - EW'(in_a_z);
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic                 s2_valid_r;
  logic signed [PW-1:0] s2_p_r [0:5];
  logic signed [EW-1:0] rx, ry, rz, ux, uy, uz;

  assign rx = s1_r_r[0];
  assign ry = s1_r_r[1];
  assign rz = s1_r_r[2];
  assign ux = s1_u_r[0];
  assign uy = s1_u_r[1];
  assign uz = s1_u_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p_r[0] <= PW'(ry) * PW'(uz);
      s2_p_r[1] <= PW'(rz) * PW'(uy);
      s2_p_r[2] <= PW'(rz) * PW'(ux);
      s2_p_r[3] <= PW'(rx) * PW'(uz);
      s2_p_r[4] <= PW'(rx) * PW'(uy);
      s2_p_r[5] <= PW'(ry) * PW'(ux);
    end
  end

  // Stage 3: cross product components, split into sign and magnitude.
  logic                  s3_valid_r;
  logic [2:0][CW-1:0]    s3_m_r;
  logic [2:0]            s3_neg_r;
  logic signed [CW-1:0]  s3_n [0:2];
  logic [2:0][CW-1:0]    s3_m_nxt;
  logic [2:0]            s3_neg_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_n[i]       = CW'(s2_p_r[2*i]) - CW'(s2_p_r[2*i+1]);
      s3_neg_nxt[i] = s3_n[i][CW-1];
      s3_m_nxt[i]   = s3_neg_nxt[i] ? CW'(-s3_n[i]) : CW'(s3_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m_r   <= s3_m_nxt;
      s3_neg_r <= s3_neg_nxt;
    end
  end

  // Stage 4: largest magnitude.
  logic               s4_valid_r;
  logic [2:0][CW-1:0] s4_m_r;
  logic [2:0]         s4_neg_r;
  logic [CW-1:0]      s4_mx_r;
  logic [CW-1:0]      s4_mx_nxt;

  always_comb begin
    s4_mx_nxt = s3_m_r[0];
    if (s3_m_r[1] > s4_mx_nxt) begin
      s4_mx_nxt = s3_m_r[1];
    end
    if (s3_m_r[2] > s4_mx_nxt) begin
      s4_mx_nxt = s3_m_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m_r   <= s3_m_r;
      s4_neg_r <= s3_neg_r;
      s4_mx_r  <= s4_mx_nxt;
    end
  end

  // Stage 5: position of the leading one of the largest magnitude.
  logic               s5_valid_r;
  logic [2:0][CW-1:0] s5_m_r;
  logic [2:0]         s5_neg_r;
  logic [5:0]         s5_pos_r;
  logic               s5_deg_r;
  logic [5:0]         s5_pos_nxt;

  always_comb begin
    s5_pos_nxt = '0;
    for (int i = 0; i < CW; i++) begin
      if (s4_mx_r[i]) begin
        s5_pos_nxt = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_m_r   <= s4_m_r;
      s5_neg_r <= s4_neg_r;
      s5_pos_r <= s5_pos_nxt;
      s5_deg_r <= (s4_mx_r == '0);
    end
  end

  // Stage 6: common shift that brings the leading one to bit 30.
  logic               s6_valid_r;
  logic [2:0][RW-1:0] s6_red_r;
  logic [2:0]         s6_neg_r;
  logic               s6_deg_r;
  logic [2:0][RW-1:0] s6_red_nxt;
  logic [CW-1:0]      s6_sh [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s5_pos_r > 6'(tun_pkg::RedTop)) begin
        s6_sh[i] = s5_m_r[i] >> (s5_pos_r - 6'(tun_pkg::RedTop));
      end else begin
        s6_sh[i] = s5_m_r[i] << (6'(tun_pkg::RedTop) - s5_pos_r);
      end
      s6_red_nxt[i] = s6_sh[i][RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_red_r <= s6_red_nxt;
      s6_neg_r <= s5_neg_r;
      s6_deg_r <= s5_deg_r;
    end
  end

  // Stage 7: squares of the scaled magnitudes.
  logic                   s7_valid_r;
  logic [2:0][2*RW-1:0]   s7_sq_r;
  tun_pkg::root_side_t    s7_side_r;
  logic [tun_pkg::RadW-1:0] s7_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq_r[i] <= (2*RW)'(s6_red_r[i]) * (2*RW)'(s6_red_r[i]);
      end
      s7_side_r.deg <= s6_deg_r;
      s7_side_r.neg <= s6_neg_r;
      s7_side_r.red <= s6_red_r;
    end
  end

  // Sum of squares, registered at the root pipeline's entry.
  assign s7_sum = tun_pkg::RadW'(s7_sq_r[0]) + tun_pkg::RadW'(s7_sq_r[1]) +
                  tun_pkg::RadW'(s7_sq_r[2]);

  // Length of the scaled vector.
  logic                       rt_valid;
  logic [tun_pkg::RootW-1:0]  rt_len;
  tun_pkg::root_side_t        rt_side;
  tun_pkg::div_side_t         dv_side_in;

  tun_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s7_valid_r),
    .in_rad    (s7_sum),
    .in_side   (s7_side_r),
    .out_valid (rt_valid),
    .out_root  (rt_len),
    .out_side  (rt_side)
  );

  assign dv_side_in.deg = rt_side.deg;
  assign dv_side_in.neg = rt_side.neg;

  // Rounded quotients of each magnitude by the length.
  logic                                dv_valid;
  logic [2:0][tun_pkg::QuotW-1:0]      dv_quot;
  tun_pkg::div_side_t                  dv_side;

  tun_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (rt_valid),
    .in_len    (rt_len),
    .in_red    (rt_side.red),
    .in_side   (dv_side_in),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Output register: clamp, apply signs, force zero for a degenerate face.
  logic                           out_valid_r;
  logic [2:0][tun_pkg::QuotW-1:0] out_norm_r;
  logic                           out_deg_r;
  logic [2:0][tun_pkg::QuotW-1:0] out_norm_nxt;
  logic [tun_pkg::QuotW-1:0]      q_clamp;

  always_comb begin
    q_clamp = '0;
    for (int i = 0; i < 3; i++) begin
      q_clamp = (dv_quot[i] > tun_pkg::OneQ14) ? tun_pkg::OneQ14 : dv_quot[i];
      if (dv_side.deg) begin
        out_norm_nxt[i] = '0;
      end else if (dv_side.neg[i]) begin
        out_norm_nxt[i] = tun_pkg::QuotW'(-q_clamp);
      end else begin
        out_norm_nxt[i] = q_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_norm_r <= out_norm_nxt;
      out_deg_r  <= dv_side.deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = out_norm_r[0];
  assign out_norm_y     = out_norm_r[1];
  assign out_norm_z     = out_norm_r[2];
  assign out_degenerate = out_deg_r;

  // A degenerate face always carries a zero normal.
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_norm_x == '0) && (out_norm_y == '0) && (out_norm_z == '0))
    else $error("degenerate word with a non-zero normal");

  // Every component stays within one unit.
  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_x <= 16'sd16384) && (out_norm_x >= -16'sd16384) &&
                  (out_norm_y <= 16'sd16384) && (out_norm_y >= -16'sd16384) &&
                  (out_norm_z <= 16'sd16384) && (out_norm_z >= -16'sd16384))
    else $error("normal component out of range");

  // The input is held exactly when a finished word is held at the output.
  a_stall_link : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output hold");

  // A held output word is kept until it is taken.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_norm_x) &&
      $stable(out_norm_y) && $stable(out_norm_z) && $stable(out_degenerate))
    else $error("held output word changed");

endmodule
